/* rtl/core/sitdt_pkg.sv */
// Shared types and constants of the signed integer to decimal text unit.
package sitdt_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned MIN_DIG_W   = 6;
  localparam int unsigned SEP_W       = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MAX_DIGITS  = 10;
  localparam int unsigned DIG_IDX_W   = $clog2(MAX_DIGITS);
  localparam int unsigned PAD_LIMIT_D = 32;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // Reciprocal of ten: q = (m * RECIP10) >> RECIP_SHIFT is exact for 32-bit m
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIGITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR  = 1'd1;

  typedef logic [3:0] digit_t;

  // One converted value waiting for the emitter
  typedef struct packed {
    logic                      neg;
    logic [DIG_IDX_W-1:0]      ndig;
    digit_t [MAX_DIGITS-1:0]   digs;
  } desc_t;

endpackage

/* rtl/core/signed_int_to_decimal_text_unit.sv */
// Top level of the signed integer to decimal text unit.
//
//   channel  direction  handshake        payload
//   in       input      in_push/in_full  in_value (32, signed)
//   out      output     out_pop/out_empty out_text_byte (8), out_last (1)
//   cfg      input      cfg_we           cfg_index (1), cfg_data (32)
//
// The front end accepts a value while idle, then splits off its decimal
// digits (1 to 10) one at a time through its divide-by-ten multiplier and
// hands them to the queue; it takes no new value until the queue has them.
// The emitter pops each value from the queue while idle, then emits its bytes.
// Synchronous active-low reset clears the registers to no padding, no grouping.
// A stalled output holds the emitter; the two-entry queue keeps the front going.
module signed_int_to_decimal_text_unit #(
  parameter int unsigned PAD_LIMIT = sitdt_pkg::PAD_LIMIT_D
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [sitdt_pkg::VALUE_W-1:0] in_value,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic [sitdt_pkg::BYTE_W-1:0]         out_text_byte,
  output logic                                 out_last,
  input  logic                                 cfg_we,
  input  logic [sitdt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sitdt_pkg::SEP_W-1:0]          cfg_data
);

  localparam logic [sitdt_pkg::MIN_DIG_W-1:0] PAD_MAX = sitdt_pkg::MIN_DIG_W'(PAD_LIMIT);

  logic [sitdt_pkg::MIN_DIG_W-1:0] min_digits_r;
  logic [sitdt_pkg::SEP_W-1:0]     sep_bytes_r;
  logic [sitdt_pkg::MIN_DIG_W-1:0] min_wr;

  logic             q_push, q_full, q_pop, q_empty;
  sitdt_pkg::desc_t q_wr_desc, q_rd_desc;

  // Clamp the padding request on write
  assign min_wr = (cfg_data[sitdt_pkg::MIN_DIG_W-1:0] > PAD_MAX) ?
                  PAD_MAX : cfg_data[sitdt_pkg::MIN_DIG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_digits_r <= '0;
      sep_bytes_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sitdt_pkg::CFG_MIN_DIGITS: min_digits_r <= min_wr;
        sitdt_pkg::CFG_SEPARATOR:  sep_bytes_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  sitdt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_value (in_value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_desc   (q_wr_desc)
  );

  sitdt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_desc (q_wr_desc),
    .full    (q_full),
    .pop     (q_pop),
    .rd_desc (q_rd_desc),
    .empty   (q_empty)
  );

  sitdt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_desc        (q_rd_desc),
    .q_pop         (q_pop),
    .min_digits    (min_digits_r),
    .sep_bytes     (sep_bytes_r),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_text_byte (out_text_byte),
    .out_last      (out_last)
  );

endmodule

/* rtl/core/sitdt_front.sv */
// Front end: accepts a value and splits its magnitude into decimal digits.
module sitdt_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [sitdt_pkg::VALUE_W-1:0] in_value,
  input  logic                                 q_full,
  output logic                                 q_push,
  output sitdt_pkg::desc_t                     q_desc
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_HOLD
  } fstate_t;

  fstate_t                            state_r, state_nxt;
  logic [sitdt_pkg::VALUE_W-1:0]      mag_r, mag_nxt;
  logic                               neg_r, neg_nxt;
  logic [sitdt_pkg::DIG_IDX_W-1:0]    cnt_r, cnt_nxt;
  sitdt_pkg::digit_t [sitdt_pkg::MAX_DIGITS-1:0] digs_r;

  logic [2*sitdt_pkg::VALUE_W-1:0]    prod;
  logic [sitdt_pkg::VALUE_W-1:0]      quo;
  logic [sitdt_pkg::VALUE_W-1:0]      quo_x10;
  logic [sitdt_pkg::VALUE_W-1:0]      rem_full;
  sitdt_pkg::digit_t                  digit;
  logic                               accept;
  logic                               conv_done;

  assign accept = in_push && !in_full;
  assign in_full = (state_r != F_IDLE);

  // Divide by ten through the reciprocal, remainder by back-multiplication
  assign prod     = {{sitdt_pkg::VALUE_W{1'b0}}, mag_r} *
                    {{sitdt_pkg::VALUE_W{1'b0}}, sitdt_pkg::RECIP10};
  assign quo      = sitdt_pkg::VALUE_W'(prod[2*sitdt_pkg::VALUE_W-1:sitdt_pkg::RECIP_SHIFT]);
  assign quo_x10  = (quo << 3) + (quo << 1);
  assign rem_full = mag_r - quo_x10;
  assign digit    = rem_full[3:0];

  assign conv_done = (quo == '0) ||
                     (cnt_r == sitdt_pkg::DIG_IDX_W'(sitdt_pkg::MAX_DIGITS - 1));

  assign q_push      = (state_r == F_HOLD) && !q_full;
  assign q_desc.neg  = neg_r;
  assign q_desc.ndig = cnt_r;
  assign q_desc.digs = digs_r;

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          neg_nxt   = in_value[sitdt_pkg::VALUE_W-1];
          mag_nxt   = in_value[sitdt_pkg::VALUE_W-1] ?
                      (sitdt_pkg::VALUE_W'(0) - in_value) : in_value;
          cnt_nxt   = '0;
          state_nxt = F_CONV;
        end
      end
      F_CONV: begin
        mag_nxt = quo;
        cnt_nxt = cnt_r + 1'b1;
        if (conv_done) begin
          state_nxt = F_HOLD;
        end
      end
      F_HOLD: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (state_r == F_CONV) begin
      digs_r[cnt_r] <= digit;
    end
  end

endmodule

/* rtl/core/sitdt_queue.sv */
// Short queue of converted values between the front end and the emitter.
module sitdt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sitdt_pkg::desc_t wr_desc,
  output logic             full,
  input  logic             pop,
  output sitdt_pkg::desc_t rd_desc,
  output logic             empty
);

  sitdt_pkg::desc_t              mem [sitdt_pkg::QDEPTH];
  logic [sitdt_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [sitdt_pkg::QPTR_W:0]    count_r;
  logic                          do_push, do_pop;

  assign full    = (count_r == (sitdt_pkg::QPTR_W+1)'(sitdt_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_desc = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
    if (do_push) begin
      mem[wr_ptr_r] <= wr_desc;
    end
  end

endmodule

/* rtl/core/sitdt_back.sv */
// Emitter: walks sign, pad zeros, digits and separators one byte per beat.
module sitdt_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  input  sitdt_pkg::desc_t                    q_desc,
  output logic                                q_pop,
  input  logic [sitdt_pkg::MIN_DIG_W-1:0]     min_digits,
  input  logic [sitdt_pkg::SEP_W-1:0]         sep_bytes,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [sitdt_pkg::BYTE_W-1:0]        out_text_byte,
  output logic                                out_last
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_SIGN,
    B_PAD,
    B_DIGIT,
    B_SEP
  } bstate_t;

  bstate_t                                       state_r, state_nxt;
  sitdt_pkg::digit_t [sitdt_pkg::MAX_DIGITS-1:0] digs_r, digs_nxt;
  logic [sitdt_pkg::DIG_IDX_W-1:0]               k_r, k_nxt;
  logic [sitdt_pkg::MIN_DIG_W-1:0]               pad_r, pad_nxt;
  logic [1:0]                                    b_r, b_nxt;
  logic [1:0]                                    trail_r, trail_nxt;
  logic                                          group_r, group_nxt;
  logic                                          ov_r, ov_nxt;
  logic [sitdt_pkg::BYTE_W-1:0]                  byte_r, byte_nxt;
  logic                                          last_r, last_nxt;

  logic                                 adv;
  logic [sitdt_pkg::BYTE_W-1:0]         lead;
  logic [1:0]                           lead_trail;
  logic                                 lead_ok;
  logic [sitdt_pkg::MIN_DIG_W-1:0]      ndig_ext;
  logic [sitdt_pkg::MIN_DIG_W-1:0]      pad_load;
  logic                                 sep_point;
  logic [sitdt_pkg::BYTE_W-1:0]         sep_byte;

  assign adv           = !ov_r || out_pop;
  assign out_empty     = !ov_r;
  assign out_text_byte = byte_r;
  assign out_last      = last_r;
  assign q_pop         = (state_r == B_IDLE) && !q_empty;

  // Separator length from the UTF-8 lead byte
  assign lead = sep_bytes[sitdt_pkg::BYTE_W-1:0];
  always_comb begin
    lead_ok    = 1'b1;
    lead_trail = 2'd0;
    if (lead < 8'h80) begin
      lead_trail = 2'd0;
    end else if (lead < 8'hC0) begin
      lead_ok = 1'b0;
    end else if (lead < 8'hE0) begin
      lead_trail = 2'd1;
    end else if (lead < 8'hF0) begin
      lead_trail = 2'd2;
    end else if (lead < 8'hF8) begin
      lead_trail = 2'd3;
    end else begin
      lead_ok = 1'b0;
    end
  end

  assign ndig_ext = sitdt_pkg::MIN_DIG_W'(q_desc.ndig);
  assign pad_load = (min_digits > ndig_ext) ? (min_digits - ndig_ext) : '0;

  assign sep_point = group_r && (k_r inside {4'd3, 4'd6, 4'd9});
  assign sep_byte  = sep_bytes[{b_r, 3'b000} +: sitdt_pkg::BYTE_W];

  always_comb begin
    state_nxt = state_r;
    digs_nxt  = digs_r;
    k_nxt     = k_r;
    pad_nxt   = pad_r;
    b_nxt     = b_r;
    trail_nxt = trail_r;
    group_nxt = group_r;
    ov_nxt    = ov_r && !out_pop;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          digs_nxt  = q_desc.digs;
          k_nxt     = q_desc.ndig - 1'b1;
          pad_nxt   = pad_load;
          trail_nxt = lead_trail;
          group_nxt = (lead != '0) && lead_ok;
          if (q_desc.neg) begin
            state_nxt = B_SIGN;
          end else if (pad_load != '0) begin
            state_nxt = B_PAD;
          end else begin
            state_nxt = B_DIGIT;
          end
        end
      end
      B_SIGN: begin
        if (adv) begin
          ov_nxt    = 1'b1;
          byte_nxt  = sitdt_pkg::CHAR_MINUS;
          last_nxt  = 1'b0;
          state_nxt = (pad_r != '0) ? B_PAD : B_DIGIT;
        end
      end
      B_PAD: begin
        if (adv) begin
          ov_nxt   = 1'b1;
          byte_nxt = sitdt_pkg::CHAR_ZERO;
          last_nxt = 1'b0;
          pad_nxt  = pad_r - 1'b1;
          if (pad_r == sitdt_pkg::MIN_DIG_W'(1)) begin
            state_nxt = B_DIGIT;
          end
        end
      end
      B_DIGIT: begin
        if (adv) begin
          ov_nxt   = 1'b1;
          byte_nxt = sitdt_pkg::CHAR_ZERO + sitdt_pkg::BYTE_W'(digs_r[k_r]);
          last_nxt = 1'b0;
          if (sep_point) begin
            b_nxt     = 2'd0;
            state_nxt = B_SEP;
          end else if (k_r == '0) begin
            last_nxt  = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            k_nxt = k_r - 1'b1;
          end
        end
      end
      B_SEP: begin
        if (adv) begin
          ov_nxt   = 1'b1;
          byte_nxt = sep_byte;
          last_nxt = 1'b0;
          if (b_r == trail_r) begin
            k_nxt     = k_r - 1'b1;
            state_nxt = B_DIGIT;
          end else begin
            b_nxt = b_r + 1'b1;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    digs_r  <= digs_nxt;
    k_r     <= k_nxt;
    pad_r   <= pad_nxt;
    b_r     <= b_nxt;
    trail_r <= trail_nxt;
    group_r <= group_nxt;
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
  end

endmodule

/* test/signed_int_to_decimal_text_unit_tb.sv */
// Self-checking testbench for the signed integer to decimal text unit.
`timescale 1ns / 1ps

module signed_int_to_decimal_text_unit_tb;

  localparam int unsigned PAD_CAP        = sitdt_pkg::PAD_LIMIT_D;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned FIXED_PHASES   = 10;
  localparam int unsigned RANDOM_PHASES  = 2;
  localparam int unsigned PHASE_ITEMS    = 38;

  localparam logic [31:0] TEN_POW [10] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
    32'd10000000, 32'd100000000, 32'd1000000000
  };
  localparam logic [31:0] EDGE_VALUES [4] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF
  };
  localparam logic [31:0] DIRECTED_VALUES [18] = '{
    32'd0, 32'd7, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100, 32'd999,
    -32'sd1000, 32'd12345, 32'd999999, 32'd1000000, 32'd123456789,
    32'd1234567890, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000
  };
  // min_digits data and separator word of each fixed setting
  localparam logic [31:0] PHASE_MIN [FIXED_PHASES] = '{
    32'd0, 32'd4, 32'd32, 32'hFFFF_FFFF, 32'd33, 32'd1, 32'd11, 32'd10, 32'd2,
    32'hFFFF_FFC7
  };
  localparam logic [31:0] PHASE_SEP [FIXED_PHASES] = '{
    32'h0000_002C, 32'h0000_A0C2, 32'h00AF_80E2, 32'h8098_9FF0, 32'h0000_0085,
    32'hFFFF_FF7F, 32'h0000_00C0, 32'h00BF_80EF, 32'h1234_56F8, 32'hABCD_EFDF
  };
  localparam logic [7:0] LEAD_BYTES [13] = '{
    8'h00, 8'h2E, 8'h7F, 8'h80, 8'hBF, 8'hC0, 8'hDF, 8'hE0, 8'hEF, 8'hF0,
    8'hF7, 8'hF8, 8'hFF
  };

  typedef struct {
    logic [sitdt_pkg::BYTE_W-1:0]  text_byte;
    logic                          last;
    logic [sitdt_pkg::VALUE_W-1:0] value;
  } text_beat_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_push = 1'b0;
  logic                                 in_full;
  logic signed [sitdt_pkg::VALUE_W-1:0] in_value = '0;
  logic                                 out_empty;
  logic                                 out_pop = 1'b0;
  logic [sitdt_pkg::BYTE_W-1:0]         out_text_byte;
  logic                                 out_last;
  logic                                 cfg_we = 1'b0;
  logic [sitdt_pkg::CFG_IDX_W-1:0]      cfg_index = sitdt_pkg::CFG_MIN_DIGITS;
  logic [sitdt_pkg::SEP_W-1:0]          cfg_data = '0;

  logic [sitdt_pkg::VALUE_W-1:0] pending_values [$];
  text_beat_t                    expected_text [$];

  // Predictor copy of the registers
  int unsigned                 pad_digits = 0;
  logic [sitdt_pkg::SEP_W-1:0] sep_word = '0;

  bit          in_taken = 1'b0;
  int unsigned in_gap = 0, in_calm = 0, pop_gap = 0, pop_calm = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned values_taken = 0, bytes_checked = 0, longest_text = 0;
  int unsigned settings_used = 1;
  bit          progress;

  signed_int_to_decimal_text_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_value      (in_value),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_text_byte (out_text_byte),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  // Expected text of one value under the current register copy
  function automatic void render_text(input logic [sitdt_pkg::VALUE_W-1:0] raw);
    logic                         neg;
    logic [31:0]                  mag;
    logic [3:0]                   digs [sitdt_pkg::MAX_DIGITS];
    int unsigned                  n, k, b, trail;
    logic [7:0]                   lead;
    bit                           group;
    logic [sitdt_pkg::BYTE_W-1:0] seq [$];
    text_beat_t                   beat;
    neg = raw[sitdt_pkg::VALUE_W-1];
    mag = neg ? (32'd0 - raw) : raw;
    n = 0;
    do begin
      digs[n] = 4'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0 && n < sitdt_pkg::MAX_DIGITS);
    lead = sep_word[7:0];
    if (lead < 8'h80) trail = 0;
    else if (lead < 8'hC0) trail = 255;
    else if (lead < 8'hE0) trail = 1;
    else if (lead < 8'hF0) trail = 2;
    else if (lead < 8'hF8) trail = 3;
    else trail = 255;
    group = (lead != 8'h00) && (trail <= 3);
    if (neg) seq.push_back(sitdt_pkg::CHAR_MINUS);
    for (k = pad_digits; k > n; k--) seq.push_back(sitdt_pkg::CHAR_ZERO);
    for (k = n; k > 0; k--) begin
      seq.push_back(sitdt_pkg::CHAR_ZERO + sitdt_pkg::BYTE_W'(digs[k-1]));
      if (group && k > 1 && ((k - 1) % 3) == 0) begin
        for (b = 0; b <= trail; b++) seq.push_back(sep_word[8*b +: 8]);
      end
    end
    for (k = 0; k < seq.size(); k++) begin
      beat.text_byte = seq[k];
      beat.last      = (k == seq.size() - 1);
      beat.value     = raw;
      expected_text.push_back(beat);
    end
    if (seq.size() > longest_text) longest_text = seq.size();
  endfunction

  function automatic logic [sitdt_pkg::VALUE_W-1:0] random_value();
    logic [31:0] m;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4:    m = $urandom_range(0, 999);
      5:       m = TEN_POW[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
      6:       return EDGE_VALUES[$urandom_range(0, 3)];
      default: m = $urandom % TEN_POW[$urandom_range(0, 9)];
    endcase
    return $urandom_range(0, 1) ? (32'd0 - m) : m;
  endfunction

  // Input driver: present the head of the pending list, drop it once taken
  always @(negedge clk) begin
    if (in_taken) begin
      in_taken = 1'b0;
      void'(pending_values.pop_front());
      if (in_calm > 0) begin
        in_calm--;
      end else begin
        in_gap = pick_gap();
        if ($urandom_range(0, 39) == 0) in_calm = $urandom_range(20, 60);
      end
    end
    if (in_gap > 0) begin
      in_gap--;
      in_push  <= 1'b0;
      in_value <= $urandom;
    end else if (pending_values.size() != 0) begin
      in_push  <= 1'b1;
      in_value <= pending_values[0];
    end else begin
      in_push  <= 1'b0;
      in_value <= $urandom;
    end
  end

  // Output side: stall at random, with stretches of steady pops
  always @(negedge clk) begin
    if (pop_calm > 0) begin
      pop_calm--;
      out_pop <= 1'b1;
    end else if (pop_gap > 0) begin
      pop_gap--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      pop_gap = pick_gap();
      if ($urandom_range(0, 49) == 0) pop_calm = $urandom_range(30, 90);
    end
  end

  // Predict on every input beat, check every output beat, watch for a hang
  always @(posedge clk) begin
    text_beat_t want;
    if (rst_n) begin
      progress = 1'b0;
      if (in_push && !in_full) begin
        render_text(in_value);
        in_taken = 1'b1;
        values_taken++;
        progress = 1'b1;
      end
      if (out_pop && !out_empty) begin
        progress = 1'b1;
        if (expected_text.size() == 0) begin
          flag_mismatch($sformatf("byte %02h (last %0b) with no text pending",
                                  out_text_byte, out_last));
        end else begin
          want = expected_text.pop_front();
          if (out_text_byte !== want.text_byte)
            flag_mismatch($sformatf("value %0d: byte %02h, want %02h",
                                    $signed(want.value), out_text_byte, want.text_byte));
          if (out_last !== want.last)
            flag_mismatch($sformatf("value %0d: last %b, want %b",
                                    $signed(want.value), out_last, want.last));
          bytes_checked++;
        end
      end
      if (progress) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no beat for %0d cycles, %0d bytes still due",
                   idle_cycles, expected_text.size());
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(input logic [sitdt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sitdt_pkg::SEP_W-1:0]     data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_data  <= $urandom;
    if (idx == sitdt_pkg::CFG_MIN_DIGITS)
      pad_digits = (data[sitdt_pkg::MIN_DIG_W-1:0] > PAD_CAP) ?
                   PAD_CAP : data[sitdt_pkg::MIN_DIG_W-1:0];
    else if (idx == sitdt_pkg::CFG_SEPARATOR)
      sep_word = data;
  endtask

  // Hold until everything sent has been taken and all its text has come back
  task automatic drain();
    while (pending_values.size() != 0) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_setting(input logic [31:0] min_data, input logic [31:0] sep_data);
    int unsigned i;
    write_reg(sitdt_pkg::CFG_MIN_DIGITS, min_data);
    write_reg(sitdt_pkg::CFG_SEPARATOR, sep_data);
    settings_used++;
    for (i = 0; i < PHASE_ITEMS; i++) pending_values.push_back(random_value());
    drain();
  endtask

  initial begin
    int unsigned p;
    logic [31:0] sep;
    int unsigned k;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset setting: no padding, no grouping
    foreach (DIRECTED_VALUES[i]) pending_values.push_back(DIRECTED_VALUES[i]);
    drain();

    for (p = 0; p < FIXED_PHASES; p++) run_setting(PHASE_MIN[p], PHASE_SEP[p]);
    for (p = 0; p < RANDOM_PHASES; p++) begin
      sep = $urandom;
      k = $urandom_range(0, 13);
      if (k < 13) sep[7:0] = LEAD_BYTES[k];
      run_setting($urandom, sep);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d values rendered into %0d text bytes over %0d register settings",
             values_taken, bytes_checked, settings_used);
    $display("longest text %0d bytes; padding to %0d digits, 1 to 4 byte and invalid separators",
             longest_text, PAD_CAP);
    if (mismatch_count == 0 && expected_text.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d bytes never arrived", mismatch_count, expected_text.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
